// ----- rtl/core/primality_test_64_assert.svh -----
// Assertion macros for the primality test core.
// Used by ptest_back under rtl/core; needs nothing else.
`ifndef PRIMALITY_TEST_64_ASSERT_SVH
`define PRIMALITY_TEST_64_ASSERT_SVH

// Check prop on every clock edge outside reset.
`define PT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check prop on every clock edge, reset included.
`define PT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ptest_pkg.sv -----
// Shared types and constants of the primality test core.
// No dependencies.
`default_nettype none

package ptest_pkg;

   localparam int unsigned IN_BITS     = 64;
   localparam int unsigned NUM_SMALL   = 12;
   localparam int unsigned NUM_WITNESS = 7;
   localparam int unsigned WIT_BITS    = 31;

   localparam logic [5:0] SMALL_PRIME [NUM_SMALL] = '{
      6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
   };

   localparam logic [WIT_BITS-1:0] WITNESS [NUM_WITNESS] = '{
      31'd2, 31'd325, 31'd9375, 31'd28178, 31'd450775, 31'd9780504, 31'd1795265022
   };

   localparam logic [2:0] LAST_WITNESS = 3'd6;

   // Classification handed from front to back.
   typedef struct packed {
      logic done;    // answer already known, skip the strong test
      logic prime;   // answer when done
   } cls_type;

   // Status of the modular multiplier.
   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SCAN,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_SPLIT,
      B_RED,
      B_RED_WT,
      B_POW,
      B_POWA_WT,
      B_POWB_WT,
      B_CHECK,
      B_SQR,
      B_SQR_WT,
      B_NEXT,
      B_OUT
   } back_state_type;

endpackage

`default_nettype wire

// ----- rtl/core/ptest_mulmod.sv -----
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle.
// Depends on ptest_pkg.
`default_nettype none

module ptest_mulmod #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      go,
   input  wire logic [VALUE_BITS-1:0]     a_op,
   input  wire logic [VALUE_BITS-1:0]     b_op,
   input  wire logic [VALUE_BITS-1:0]     m_op,
   output ptest_pkg::mm_status_type       status,
   output logic [VALUE_BITS-1:0]          prod
);

   localparam int unsigned CW = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] a_ff, a_in;
   logic [VALUE_BITS-1:0] b_ff, b_in;
   logic [VALUE_BITS-1:0] m_ff, m_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;

   logic [VALUE_BITS:0]   dbl, sum, m_ext;
   logic [VALUE_BITS-1:0] half, addend;

   // Double the accumulator, then add a when the current bit of b is set.
   always_comb begin
      m_ext  = {1'b0, m_ff};
      dbl    = {acc_ff, 1'b0};
      half   = (dbl >= m_ext) ? VALUE_BITS'(dbl - m_ext) : VALUE_BITS'(dbl);
      addend = b_ff[VALUE_BITS-1] ? a_ff : '0;
      sum    = {1'b0, half} + {1'b0, addend};
   end

   // Load on go, step while busy, pulse done after the last bit.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      if (go && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CW'(VALUE_BITS - 1);
         a_in    = a_op;
         b_in    = b_op;
         m_in    = m_op;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = (sum >= m_ext) ? VALUE_BITS'(sum - m_ext) : VALUE_BITS'(sum);
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign prod        = acc_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ptest_front.sv -----
// Front end: accepts a value and screens it by trial division by 2..37.
// Depends on ptest_pkg.
`default_nettype none

module ptest_front #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [ptest_pkg::IN_BITS-1:0] req_value,
   output logic                             q_push,
   input  wire logic                        q_full,
   output logic [VALUE_BITS-1:0]            q_value,
   output ptest_pkg::cls_type               q_cls
);

   localparam int unsigned CW = $clog2(VALUE_BITS);

   ptest_pkg::front_state_type state_ff, state_in;
   logic [VALUE_BITS-1:0]      val_ff, val_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [5:0]                 rem_ff [ptest_pkg::NUM_SMALL];
   logic [5:0]                 rem_in [ptest_pkg::NUM_SMALL];
   logic [5:0]                 rem_step [ptest_pkg::NUM_SMALL];
   logic [ptest_pkg::NUM_SMALL-1:0] divides, equals;
   logic                       below_two;

   // One remainder step per prime: r = (2r + bit) mod p.
   for (genvar g = 0; g < ptest_pkg::NUM_SMALL; g++) begin : g_rem
      logic [6:0] t;
      always_comb begin
         t           = {rem_ff[g], val_ff[cnt_ff]};
         rem_step[g] = (t >= {1'b0, ptest_pkg::SMALL_PRIME[g]})
                       ? 6'(t - {1'b0, ptest_pkg::SMALL_PRIME[g]}) : 6'(t);
      end
      assign divides[g] = (rem_ff[g] == '0);
      assign equals[g]  = (val_ff == VALUE_BITS'(ptest_pkg::SMALL_PRIME[g]));
   end

   assign below_two = (val_ff < VALUE_BITS'(2));

   // Classify once the scan is over.
   always_comb begin
      q_cls.done  = below_two || (|divides);
      q_cls.prime = !below_two && (|equals);
   end

   always_comb begin
      state_in = state_ff;
      val_in   = val_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      q_push   = 1'b0;
      case (state_ff)
         ptest_pkg::F_IDLE: begin
            if (req_push) begin
               val_in   = req_value[VALUE_BITS-1:0];
               cnt_in   = CW'(VALUE_BITS - 1);
               for (int i = 0; i < ptest_pkg::NUM_SMALL; i++) rem_in[i] = '0;
               state_in = ptest_pkg::F_SCAN;
            end
         end
         ptest_pkg::F_SCAN: begin
            rem_in = rem_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ptest_pkg::F_PUSH;
         end
         ptest_pkg::F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = ptest_pkg::F_IDLE;
            end
         end
         default: state_in = ptest_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptest_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      val_ff <= val_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
   end

   assign req_full = (state_ff != ptest_pkg::F_IDLE);
   assign q_value  = val_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ptest_queue.sv -----
// Two-entry queue between the front end and the back end.
// Depends on ptest_pkg.
`default_nettype none

module ptest_queue #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [VALUE_BITS-1:0] wr_value,
   input  ptest_pkg::cls_type         wr_cls,
   input  wire logic                  pop,
   output logic                       empty,
   output logic [VALUE_BITS-1:0]      rd_value,
   output ptest_pkg::cls_type         rd_cls
);

   logic [VALUE_BITS-1:0] val_mem [2];
   ptest_pkg::cls_type    cls_mem [2];
   logic                  wp_ff, wp_in;
   logic                  rp_ff, rp_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and count.
   always_comb begin
      wp_in  = do_push ? !wp_ff : wp_ff;
      rp_in  = do_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         val_mem[wp_ff] <= wr_value;
         cls_mem[wp_ff] <= wr_cls;
      end
   end

   assign rd_value = val_mem[rp_ff];
   assign rd_cls   = cls_mem[rp_ff];

endmodule

`default_nettype wire

// ----- rtl/core/ptest_back.sv -----
// Back end: strong probable-prime test over seven fixed witnesses.
// Depends on ptest_pkg, ptest_mulmod and primality_test_64_assert.svh.
`default_nettype none
`include "primality_test_64_assert.svh"

module ptest_back #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   output logic                       q_pop,
   input  wire logic [VALUE_BITS-1:0] q_value,
   input  ptest_pkg::cls_type         q_cls,
   input  wire logic                  out_free,
   output logic                       out_wr,
   output logic                       out_prime
);

   localparam int unsigned CW = $clog2(VALUE_BITS);

   ptest_pkg::back_state_type state_ff, state_in;
   logic [VALUE_BITS-1:0] n_ff, n_in;
   logic [VALUE_BITS-1:0] d_ff, d_in;
   logic [VALUE_BITS-1:0] e_ff, e_in;
   logic [VALUE_BITS-1:0] base_ff, base_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [CW-1:0]         s_ff, s_in;
   logic [CW-1:0]         r_ff, r_in;
   logic [2:0]            widx_ff, widx_in;
   logic                  prime_ff, prime_in;

   logic                      mm_go;
   logic [VALUE_BITS-1:0]     mm_a, mm_b, mm_prod, n_less;
   ptest_pkg::mm_status_type  mm_st;

   assign n_less = n_ff - 1'b1;

   ptest_mulmod #(.VALUE_BITS(VALUE_BITS)) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .go     (mm_go),
      .a_op   (mm_a),
      .b_op   (mm_b),
      .m_op   (n_ff),
      .status (mm_st),
      .prod   (mm_prod)
   );

   // Sequence: split n-1, reduce witness, power, then repeated squaring.
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      s_in     = s_ff;
      r_in     = r_ff;
      widx_in  = widx_ff;
      prime_in = prime_ff;
      q_pop    = 1'b0;
      out_wr   = 1'b0;
      mm_go    = 1'b0;
      mm_a     = acc_ff;
      mm_b     = base_ff;
      case (state_ff)
         ptest_pkg::B_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               n_in  = q_value;
               if (q_cls.done) begin
                  prime_in = q_cls.prime;
                  state_in = ptest_pkg::B_OUT;
               end else begin
                  d_in     = q_value - 1'b1;
                  s_in     = '0;
                  state_in = ptest_pkg::B_SPLIT;
               end
            end
         end
         ptest_pkg::B_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               s_in = s_ff + 1'b1;
            end else begin
               widx_in  = '0;
               state_in = ptest_pkg::B_RED;
            end
         end
         ptest_pkg::B_RED: begin
            // witness mod n as 1 * witness
            mm_go    = 1'b1;
            mm_a     = VALUE_BITS'(1);
            mm_b     = VALUE_BITS'(ptest_pkg::WITNESS[widx_ff]);
            state_in = ptest_pkg::B_RED_WT;
         end
         ptest_pkg::B_RED_WT: begin
            if (mm_st.done) begin
               if (mm_prod == '0) begin
                  state_in = ptest_pkg::B_NEXT;
               end else begin
                  base_in  = mm_prod;
                  e_in     = d_ff;
                  acc_in   = VALUE_BITS'(1);
                  state_in = ptest_pkg::B_POW;
               end
            end
         end
         ptest_pkg::B_POW: begin
            if (e_ff == '0) begin
               state_in = ptest_pkg::B_CHECK;
            end else if (e_ff[0]) begin
               mm_go    = 1'b1;
               state_in = ptest_pkg::B_POWA_WT;
            end else begin
               mm_go    = 1'b1;
               mm_a     = base_ff;
               state_in = ptest_pkg::B_POWB_WT;
            end
         end
         ptest_pkg::B_POWA_WT: begin
            if (mm_st.done) begin
               acc_in   = mm_prod;
               mm_go    = 1'b1;
               mm_a     = base_ff;
               state_in = ptest_pkg::B_POWB_WT;
            end
         end
         ptest_pkg::B_POWB_WT: begin
            if (mm_st.done) begin
               base_in  = mm_prod;
               e_in     = e_ff >> 1;
               state_in = ptest_pkg::B_POW;
            end
         end
         ptest_pkg::B_CHECK: begin
            if (acc_ff == VALUE_BITS'(1) || acc_ff == n_less) begin
               state_in = ptest_pkg::B_NEXT;
            end else begin
               r_in     = CW'(1);
               state_in = ptest_pkg::B_SQR;
            end
         end
         ptest_pkg::B_SQR: begin
            if (r_ff < s_ff) begin
               mm_go    = 1'b1;
               mm_b     = acc_ff;
               state_in = ptest_pkg::B_SQR_WT;
            end else begin
               prime_in = 1'b0;
               state_in = ptest_pkg::B_OUT;
            end
         end
         ptest_pkg::B_SQR_WT: begin
            if (mm_st.done) begin
               acc_in   = mm_prod;
               r_in     = r_ff + 1'b1;
               state_in = (mm_prod == n_less) ? ptest_pkg::B_NEXT : ptest_pkg::B_SQR;
            end
         end
         ptest_pkg::B_NEXT: begin
            if (widx_ff == ptest_pkg::LAST_WITNESS) begin
               prime_in = 1'b1;
               state_in = ptest_pkg::B_OUT;
            end else begin
               widx_in  = widx_ff + 1'b1;
               state_in = ptest_pkg::B_RED;
            end
         end
         ptest_pkg::B_OUT: begin
            if (out_free) begin
               out_wr   = 1'b1;
               state_in = ptest_pkg::B_IDLE;
            end
         end
         default: state_in = ptest_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptest_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff     <= n_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      base_ff  <= base_in;
      acc_ff   <= acc_in;
      s_ff     <= s_in;
      r_ff     <= r_in;
      widx_ff  <= widx_in;
      prime_ff <= prime_in;
   end

   assign out_prime = prime_ff;

   `PT_ASSERT(a_go_idle, clock, reset, mm_go |-> !mm_st.busy, "multiplier started while busy")
   `PT_ASSERT(a_pop_ok, clock, reset, q_pop |-> !q_empty, "pop from empty queue")
   `PT_ASSERT(a_done_wait, clock, reset, mm_st.done |-> $past(mm_st.busy), "done without work")
   `PT_ASSERT_ALWAYS(a_wr_once, clock, out_wr |=> !out_wr, "result written twice")

endmodule

`default_nettype wire

// ----- rtl/core/primality_test_64.sv -----
// Channel   Ports                         Direction
// request   req_push/req_full/req_value    in  (queue write side)
// response  rsp_pop/rsp_empty/rsp_prime    out (queue read side)
//
// Front end screens each value one bit per cycle through twelve remainder
// chains. The back end runs one bit-serial modular multiplier; a full
// strong test takes up to about 7 * 2 * VALUE_BITS products.
// Reset is synchronous and clears all control state; the front may take a new
// value while the back end still works and a result waits to be popped.
// Top level of the primality test; depends on ptest_pkg, ptest_front,
// ptest_queue and ptest_back.
`default_nettype none

module primality_test_64 #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [ptest_pkg::IN_BITS-1:0] req_value,
   input  wire logic                          rsp_pop,
   output logic                               rsp_empty,
   output logic                               rsp_prime
);

   logic                  q_push, q_full, q_pop, q_empty;
   logic [VALUE_BITS-1:0] q_wr_value, q_rd_value;
   ptest_pkg::cls_type    q_wr_cls, q_rd_cls;
   logic                  out_wr, out_prime, out_free;
   logic                  valid_ff, valid_in;
   logic                  prime_ff, prime_in;

   ptest_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .q_push    (q_push),
      .q_full    (q_full),
      .q_value   (q_wr_value),
      .q_cls     (q_wr_cls)
   );

   ptest_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .full     (q_full),
      .wr_value (q_wr_value),
      .wr_cls   (q_wr_cls),
      .pop      (q_pop),
      .empty    (q_empty),
      .rd_value (q_rd_value),
      .rd_cls   (q_rd_cls)
   );

   ptest_back #(.VALUE_BITS(VALUE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_value   (q_rd_value),
      .q_cls     (q_rd_cls),
      .out_free  (out_free),
      .out_wr    (out_wr),
      .out_prime (out_prime)
   );

   // Hold one result until popped.
   assign out_free = !valid_ff || rsp_pop;

   always_comb begin
      valid_in = valid_ff;
      prime_in = prime_ff;
      if (rsp_pop && valid_ff) valid_in = 1'b0;
      if (out_wr) begin
         valid_in = 1'b1;
         prime_in = out_prime;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prime_ff <= prime_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_prime = prime_ff;

endmodule

`default_nettype wire
